@@ rtl/wse_pkg.sv @@
package wse_pkg;

	localparam int MAX_PROCESSES_DEF = 1024;

	// fixed field widths
	localparam int BURST_W   = 16;
	localparam int ARRIVAL_W = 24;
	localparam int PRIO_W    = 8;
	localparam int COUNT_W   = 11;
	localparam int MEANB_W   = 24;
	localparam int SDB_W     = 24;
	localparam int RATE_W    = 27;
	localparam int MEANP_W   = 16;
	localparam int SDP_W     = 16;
	localparam int RATIO_W   = 17;
	localparam int SPAN_W    = ARRIVAL_W + 1;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 184;

	// math unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic mem_busy;  // back end is reading the stores
		logic take;      // back end takes the pending job this cycle
	} wse_back_stat_t;

endpackage

@@ rtl/wse_math.sv @@
module wse_math #(
	parameter int AW = 70
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    op,
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	output logic          done,
	output logic [AW-1:0] res
);

	localparam int CNT_W = $clog2(AW + 1);
	localparam logic [1:0] OP_SQRT_L = wse_pkg::OP_SQRT;

	logic [AW+1:0]  r_q;
	logic [AW-1:0]  x_q;
	logic [AW-1:0]  y_q;
	logic [AW-1:0]  z_q;
	logic [1:0]     op_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [AW:0]    tmpd;
	logic           ge_d;
	logic [AW+1:0]  tmps;
	logic [AW+1:0]  trial;
	logic           ge_s;

	assign tmpd  = {r_q[AW-1:0], x_q[AW-1]};
	assign ge_d  = tmpd >= {1'b0, y_q};
	assign tmps  = {r_q[AW-1:0], x_q[AW-1:AW-2]};
	assign trial = {z_q, 2'b01};
	assign ge_s  = tmps >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (op == OP_SQRT_L) ? CNT_W'(AW / 2) : CNT_W'(AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= '0;
			x_q  <= a;
			y_q  <= b;
			z_q  <= '0;
			op_q <= op;
		end else if (busy_q) begin
			unique case (op_q)
				wse_pkg::OP_MUL: begin
					if (y_q[0])
						r_q <= r_q + {2'b00, x_q};
					x_q <= {x_q[AW-2:0], 1'b0};
					y_q <= {1'b0, y_q[AW-1:1]};
				end
				wse_pkg::OP_DIV: begin
					r_q <= ge_d ? (AW+2)'(tmpd - {1'b0, y_q}) : (AW+2)'(tmpd);
					x_q <= {x_q[AW-2:0], ge_d};
				end
				wse_pkg::OP_SQRT: begin
					r_q <= ge_s ? (tmps - trial) : tmps;
					x_q <= {x_q[AW-3:0], 2'b00};
					z_q <= {z_q[AW-2:0], ge_s};
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			wse_pkg::OP_MUL: res = r_q[AW-1:0];
			wse_pkg::OP_DIV: res = x_q;
			default:         res = z_q;
		endcase
	end

	assign done = done_q;

endmodule

@@ rtl/wse_front.sv @@
module wse_front #(
	parameter int MAXP = wse_pkg::MAX_PROCESSES_DEF,
	parameter int CW   = $clog2(MAXP + 1),
	parameter int ADW  = (MAXP > 1) ? $clog2(MAXP) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wse_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	input  wse_pkg::wse_back_stat_t        stat,
	// store write port
	output logic                           wr_en,
	output logic [ADW-1:0]                 wr_addr,
	output logic [wse_pkg::BURST_W-1:0]    wr_burst,
	output logic [wse_pkg::PRIO_W-1:0]     wr_prio,
	// pending job
	output logic                           job_valid,
	output logic [CW-1:0]                  job_n,
	output logic [wse_pkg::BURST_W+CW-1:0] job_bt,
	output logic [wse_pkg::PRIO_W+CW-1:0]  job_pt,
	output logic [wse_pkg::BURST_W-1:0]    job_minb,
	output logic [wse_pkg::BURST_W-1:0]    job_maxb,
	output logic [wse_pkg::ARRIVAL_W-1:0]  job_early,
	output logic [wse_pkg::ARRIVAL_W-1:0]  job_late
);

	logic [CW-1:0]                  cnt_q;
	logic [wse_pkg::BURST_W+CW-1:0] bt_q;
	logic [wse_pkg::PRIO_W+CW-1:0]  pt_q;
	logic [wse_pkg::BURST_W-1:0]    minb_q, maxb_q;
	logic [wse_pkg::ARRIVAL_W-1:0]  early_q, late_q;
	logic                           job_valid_q;

	logic [wse_pkg::BURST_W-1:0]    burst;
	logic [wse_pkg::ARRIVAL_W-1:0]  arrival;
	logic [wse_pkg::PRIO_W-1:0]     prio;
	logic                           acc, upd;
	logic [CW-1:0]                  cnt_d;
	logic [wse_pkg::BURST_W+CW-1:0] bt_d;
	logic [wse_pkg::PRIO_W+CW-1:0]  pt_d;
	logic [wse_pkg::BURST_W-1:0]    minb_d, maxb_d;
	logic [wse_pkg::ARRIVAL_W-1:0]  early_d, late_d;

	assign burst   = s_tdata[15:0];
	assign arrival = s_tdata[39:16];
	assign prio    = s_tdata[47:40];

	assign s_tready = !job_valid_q && !stat.mem_busy;
	assign acc      = s_tvalid && s_tready;
	// records past a full store are dropped, their last flag still closes the set
	assign upd      = acc && (cnt_q != CW'(MAXP));

	always_comb begin
		cnt_d   = cnt_q;
		bt_d    = bt_q;
		pt_d    = pt_q;
		minb_d  = minb_q;
		maxb_d  = maxb_q;
		early_d = early_q;
		late_d  = late_q;
		if (upd) begin
			cnt_d   = cnt_q + 1'b1;
			bt_d    = bt_q + (wse_pkg::BURST_W+CW)'(burst);
			pt_d    = pt_q + (wse_pkg::PRIO_W+CW)'(prio);
			minb_d  = (burst < minb_q) ? burst : minb_q;
			maxb_d  = (burst > maxb_q) ? burst : maxb_q;
			early_d = (arrival < early_q) ? arrival : early_q;
			late_d  = (arrival > late_q) ? arrival : late_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bt_q        <= '0;
			pt_q        <= '0;
			minb_q      <= '1;
			maxb_q      <= '0;
			early_q     <= '1;
			late_q      <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (stat.take)
				job_valid_q <= 1'b0;
			if (acc && s_tlast) begin
				job_valid_q <= 1'b1;
				cnt_q       <= '0;
				bt_q        <= '0;
				pt_q        <= '0;
				minb_q      <= '1;
				maxb_q      <= '0;
				early_q     <= '1;
				late_q      <= '0;
			end else begin
				cnt_q   <= cnt_d;
				bt_q    <= bt_d;
				pt_q    <= pt_d;
				minb_q  <= minb_d;
				maxb_q  <= maxb_d;
				early_q <= early_d;
				late_q  <= late_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && s_tlast) begin
			job_n     <= cnt_d;
			job_bt    <= bt_d;
			job_pt    <= pt_d;
			job_minb  <= minb_d;
			job_maxb  <= maxb_d;
			job_early <= early_d;
			job_late  <= late_d;
		end
	end

	assign job_valid = job_valid_q;
	assign wr_en     = upd;
	assign wr_addr   = cnt_q[ADW-1:0];
	assign wr_burst  = burst;
	assign wr_prio   = prio;

endmodule

@@ rtl/wse_back.sv @@
module wse_back #(
	parameter int MAXP = wse_pkg::MAX_PROCESSES_DEF,
	parameter int CW   = $clog2(MAXP + 1),
	parameter int ADW  = (MAXP > 1) ? $clog2(MAXP) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ADW-1:0]                 wr_addr,
	input  logic [wse_pkg::BURST_W-1:0]    wr_burst,
	input  logic [wse_pkg::PRIO_W-1:0]     wr_prio,
	input  logic                           job_valid,
	input  logic [CW-1:0]                  job_n,
	input  logic [wse_pkg::BURST_W+CW-1:0] job_bt,
	input  logic [wse_pkg::PRIO_W+CW-1:0]  job_pt,
	input  logic [wse_pkg::BURST_W-1:0]    job_minb,
	input  logic [wse_pkg::BURST_W-1:0]    job_maxb,
	input  logic [wse_pkg::ARRIVAL_W-1:0]  job_early,
	input  logic [wse_pkg::ARRIVAL_W-1:0]  job_late,
	output wse_pkg::wse_back_stat_t        stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wse_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int AW    = 2 * CW + 48;
	localparam int BT_W  = wse_pkg::BURST_W + CW;
	localparam int PT_W  = wse_pkg::PRIO_W + CW;
	localparam int BSQ_W = 2 * wse_pkg::BURST_W + CW;
	localparam int PSQ_W = 2 * wse_pkg::PRIO_W + CW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [3:0] SP_MEANB = 4'd0;
	localparam logic [3:0] SP_MEANP = 4'd1;
	localparam logic [3:0] SP_RATE  = 4'd2;
	localparam logic [3:0] SP_SHORT = 4'd3;
	localparam logic [3:0] SP_LONG  = 4'd4;
	localparam logic [3:0] SP_NN    = 4'd5;
	localparam logic [3:0] SP_B_NS2 = 4'd6;
	localparam logic [3:0] SP_B_S1S = 4'd7;
	localparam logic [3:0] SP_B_DIV = 4'd8;
	localparam logic [3:0] SP_B_SQR = 4'd9;
	localparam logic [3:0] SP_P_NS2 = 4'd10;
	localparam logic [3:0] SP_P_S1S = 4'd11;
	localparam logic [3:0] SP_P_DIV = 4'd12;
	localparam logic [3:0] SP_P_SQR = 4'd13;

	logic [wse_pkg::BURST_W-1:0] bmem [MAXP];
	logic [wse_pkg::PRIO_W-1:0]  pmem [MAXP];

	logic [2:0]     state_q;
	logic [3:0]     step_q;
	logic           issued_q;
	logic [CW-1:0]  rd_cnt_q;

	logic [CW-1:0]                 n_q;
	logic [BT_W-1:0]               bt_q;
	logic [PT_W-1:0]               pt_q;
	logic [wse_pkg::BURST_W-1:0]   minb_q, maxb_q;
	logic [wse_pkg::SPAN_W-1:0]    span_q;

	logic                          v_s1, v_s2;
	logic [wse_pkg::BURST_W-1:0]   b_s1;
	logic [wse_pkg::PRIO_W-1:0]    p_s1;
	logic [2*wse_pkg::BURST_W-1:0] bsq_s2;
	logic [2*wse_pkg::PRIO_W-1:0]  psq_s2;
	logic                          le_s2;

	logic [BSQ_W-1:0] bsq_q;
	logic [PSQ_W-1:0] psq_q;
	logic [CW-1:0]    sh_q, lg_q;

	logic [AW-1:0] nn_q, t_q, d_q, sc_q;
	logic [wse_pkg::MEANB_W-1:0] meanb_q;
	logic [wse_pkg::SDB_W-1:0]   sdb_q;
	logic [wse_pkg::RATE_W-1:0]  rate_q;
	logic [wse_pkg::MEANP_W-1:0] meanp_q;
	logic [wse_pkg::SDP_W-1:0]   sdp_q;
	logic [wse_pkg::RATIO_W-1:0] sr_q, lr_q;

	logic          take;
	logic          m_start;
	logic [1:0]    m_op;
	logic [AW-1:0] m_a, m_b, m_res;
	logic          m_done;

	assign take = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bmem[wr_addr] <= wr_burst;
			pmem[wr_addr] <= wr_prio;
		end
		b_s1 <= bmem[rd_cnt_q[ADW-1:0]];
		p_s1 <= pmem[rd_cnt_q[ADW-1:0]];
	end

	// scan pipeline: read, square and compare, accumulate
	always_ff @(posedge clk) begin
		bsq_s2 <= b_s1 * b_s1;
		psq_s2 <= p_s1 * p_s1;
		le_s2  <= (BT_W'(b_s1) * BT_W'(n_q)) <= bt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= SP_MEANB;
			issued_q <= 1'b0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					if (job_valid)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == n_q - 1'b1)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q  <= ST_CALC;
						step_q   <= SP_MEANB;
						issued_q <= 1'b0;
					end
				end
				ST_CALC: begin
					if (!issued_q)
						issued_q <= 1'b1;
					else if (m_done) begin
						issued_q <= 1'b0;
						if (step_q == SP_P_SQR)
							state_q <= ST_OUT;
						else
							step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			n_q    <= job_n;
			bt_q   <= job_bt;
			pt_q   <= job_pt;
			minb_q <= job_minb;
			maxb_q <= job_maxb;
			span_q <= (job_late < job_early) ? wse_pkg::SPAN_W'(1)
				: wse_pkg::SPAN_W'(job_late) - wse_pkg::SPAN_W'(job_early)
				+ wse_pkg::SPAN_W'(1);
			bsq_q  <= '0;
			psq_q  <= '0;
			sh_q   <= '0;
			lg_q   <= '0;
		end else if (v_s2) begin
			bsq_q <= bsq_q + BSQ_W'(bsq_s2);
			psq_q <= psq_q + PSQ_W'(psq_s2);
			if (le_s2)
				sh_q <= sh_q + 1'b1;
			else
				lg_q <= lg_q + 1'b1;
		end
	end

	// operands of each step
	always_comb begin
		m_op = wse_pkg::OP_DIV;
		m_a  = '0;
		m_b  = AW'(n_q);
		unique case (step_q)
			SP_MEANB: m_a = AW'({bt_q, 8'd0});
			SP_MEANP: m_a = AW'({pt_q, 8'd0});
			SP_RATE: begin
				m_a = AW'({n_q, 16'd0});
				m_b = AW'(span_q);
			end
			SP_SHORT: m_a = AW'({sh_q, 16'd0});
			SP_LONG:  m_a = AW'({lg_q, 16'd0});
			SP_NN: begin
				m_op = wse_pkg::OP_MUL;
				m_a  = AW'(n_q);
			end
			SP_B_NS2: begin
				m_op = wse_pkg::OP_MUL;
				m_a  = AW'(bsq_q);
			end
			SP_B_S1S, SP_P_S1S: begin
				m_op = wse_pkg::OP_MUL;
				m_a  = (step_q == SP_B_S1S) ? AW'(bt_q) : AW'(pt_q);
				m_b  = (step_q == SP_B_S1S) ? AW'(bt_q) : AW'(pt_q);
			end
			SP_B_DIV, SP_P_DIV: begin
				m_a = {d_q[AW-17:0], 16'd0};
				m_b = nn_q;
			end
			SP_B_SQR, SP_P_SQR: begin
				m_op = wse_pkg::OP_SQRT;
				m_a  = sc_q;
			end
			SP_P_NS2: begin
				m_op = wse_pkg::OP_MUL;
				m_a  = AW'(psq_q);
			end
			default: m_a = '0;
		endcase
	end

	assign m_start = (state_q == ST_CALC) && !issued_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && m_done) begin
			unique case (step_q)
				SP_MEANB: meanb_q <= m_res[wse_pkg::MEANB_W-1:0];
				SP_MEANP: meanp_q <= m_res[wse_pkg::MEANP_W-1:0];
				SP_RATE:  rate_q  <= m_res[wse_pkg::RATE_W-1:0];
				SP_SHORT: sr_q    <= m_res[wse_pkg::RATIO_W-1:0];
				SP_LONG:  lr_q    <= m_res[wse_pkg::RATIO_W-1:0];
				SP_NN:    nn_q    <= m_res;
				SP_B_NS2, SP_P_NS2: t_q <= m_res;
				SP_B_S1S, SP_P_S1S: d_q <= t_q - m_res;
				SP_B_DIV, SP_P_DIV: sc_q <= m_res;
				SP_B_SQR: sdb_q <= m_res[wse_pkg::SDB_W-1:0];
				SP_P_SQR: sdp_q <= m_res[wse_pkg::SDP_W-1:0];
				default:  t_q   <= t_q;
			endcase
		end
	end

	wse_math #(.AW(AW)) u_math (
		.clk   (clk),
		.arst_n(arst_n),
		.start (m_start),
		.op    (m_op),
		.a     (m_a),
		.b     (m_b),
		.done  (m_done),
		.res   (m_res)
	);

	assign stat.mem_busy = (state_q == ST_SCAN) || (state_q == ST_DRAIN);
	assign stat.take     = take;

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {lr_q, sr_q, sdp_q, meanp_q, rate_q, maxb_q, minb_q,
		sdb_q, meanb_q, wse_pkg::COUNT_W'(n_q)};

endmodule

@@ rtl/workload_statistics_extractor.sv @@
// Workload statistics extractor.
// Slave stream: one process record per beat, tdata = burst_length[15:0],
// arrival_tick[39:16], job_priority[47:40]; tlast marks the last record.
// Master stream: one result beat per workload, sent after the last record.
// Records load at one per cycle while s_tready is high. With the back end
// idle, s_tready stays low after the last record while the set is handed
// over, both stores are read and the read pipeline drains. The back end then
// runs fourteen shift/add and shift/subtract steps, two of them square roots,
// on one shared bit-serial unit; the next set loads meanwhile. The result
// beat holds until m_tready; a second finished set waits in the one-entry
// job queue with s_tready low. Reset clears the front end's sums and
// extremes and empties the queue; the stores need no clearing, only entries
// written for the current set are read. Records beyond MAX_PROCESSES are
// dropped.
module workload_statistics_extractor #(
	parameter int MAX_PROCESSES = wse_pkg::MAX_PROCESSES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// burst_length, arrival_tick, job_priority
	input  logic [wse_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// process_count, mean_burst_q8, burst_stddev_q8, shortest_burst,
	// longest_burst, arrival_rate_q16, mean_priority_q8, priority_stddev_q8,
	// short_ratio_q16, long_ratio_q16
	output logic [wse_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int CW  = $clog2(MAX_PROCESSES + 1);
	localparam int ADW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

	wse_pkg::wse_back_stat_t       stat;
	logic                          wr_en;
	logic [ADW-1:0]                wr_addr;
	logic [wse_pkg::BURST_W-1:0]   wr_burst;
	logic [wse_pkg::PRIO_W-1:0]    wr_prio;
	logic                          job_valid;
	logic [CW-1:0]                 job_n;
	logic [wse_pkg::BURST_W+CW-1:0] job_bt;
	logic [wse_pkg::PRIO_W+CW-1:0] job_pt;
	logic [wse_pkg::BURST_W-1:0]   job_minb, job_maxb;
	logic [wse_pkg::ARRIVAL_W-1:0] job_early, job_late;

	wse_front #(.MAXP(MAX_PROCESSES), .CW(CW), .ADW(ADW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_burst (wr_burst),
		.wr_prio  (wr_prio),
		.job_valid(job_valid),
		.job_n    (job_n),
		.job_bt   (job_bt),
		.job_pt   (job_pt),
		.job_minb (job_minb),
		.job_maxb (job_maxb),
		.job_early(job_early),
		.job_late (job_late)
	);

	wse_back #(.MAXP(MAX_PROCESSES), .CW(CW), .ADW(ADW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_burst (wr_burst),
		.wr_prio  (wr_prio),
		.job_valid(job_valid),
		.job_n    (job_n),
		.job_bt   (job_bt),
		.job_pt   (job_pt),
		.job_minb (job_minb),
		.job_maxb (job_maxb),
		.job_early(job_early),
		.job_late (job_late),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ rtl/wse_checker.sv @@
module wse_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wse_pkg::OUT_DATA_W-1:0] m_tdata
);

	// last record always parks a job, so the next beat cannot be taken at once
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after last record");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[74:59] <= m_tdata[90:75])
		else $error("shortest burst above longest");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

endmodule

bind workload_statistics_extractor wse_checker u_wse_checker (.*);
